>>> rtl/watch_slot_pool_defines.svh
// Assertion macros for the watch slot pool checker.
// No dependencies; included by rtl/wsp_checker.sv.
`ifndef WATCH_SLOT_POOL_DEFINES_SVH
`define WATCH_SLOT_POOL_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define WSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("watch_slot_pool: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define WSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("watch_slot_pool: next-cycle check failed");

`endif

>>> rtl/wsp_pkg.sv
// Shared types and codes for the watch slot pool.
// No dependencies; used by every module in rtl/.
package wsp_pkg;

    localparam int ID_W       = 32;
    localparam int SLOT_NUM_W = 5;
    localparam int RES_VAL_W  = 32;

    localparam logic [ID_W-1:0] NO_ID = '1;

    // command codes
    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_CHECK  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_SEARCH,
        S_UNLINK
    } wsp_state_t;

    // write enables into the slot store
    typedef struct packed {
        logic link_we;
        logic id_we;
        logic val_we;
    } wsp_wr_t;

endpackage

>>> rtl/wsp_store.sv
// Slot store: link, id and value memories with registered reads.
// Depends on wsp_pkg. Link entries never written read as their reset link.
module wsp_store #(
    parameter int POOL_SLOTS = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rd_en,
    input  logic [$clog2(POOL_SLOTS)-1:0]    rd_addr,
    input  wsp_pkg::wsp_wr_t                 wr,
    input  logic [$clog2(POOL_SLOTS)-1:0]    wr_addr,
    input  logic [$clog2(POOL_SLOTS+1)-1:0]  wr_link,
    input  logic [wsp_pkg::ID_W-1:0]         wr_id,
    input  logic [VALUE_BITS-1:0]            wr_val,
    output logic [$clog2(POOL_SLOTS+1)-1:0]  rd_link,
    output logic [wsp_pkg::ID_W-1:0]         rd_id,
    output logic [VALUE_BITS-1:0]            rd_val
);
    import wsp_pkg::*;

    localparam int SLOT_W = $clog2(POOL_SLOTS);
    localparam int LINK_W = $clog2(POOL_SLOTS + 1);

    logic [LINK_W-1:0]     link_mem [POOL_SLOTS];
    logic [ID_W-1:0]       id_mem   [POOL_SLOTS];
    logic [VALUE_BITS-1:0] val_mem  [POOL_SLOTS];

    logic [POOL_SLOTS-1:0] valid_reg;
    logic [LINK_W-1:0]     link_q_reg;
    logic [ID_W-1:0]       rd_id_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;
    logic [SLOT_W-1:0]     rd_addr_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.link_we)
        begin
            link_mem[wr_addr] <= wr_link;
        end
        if (wr.id_we)
        begin
            id_mem[wr_addr] <= wr_id;
        end
        if (wr.val_we)
        begin
            val_mem[wr_addr] <= wr_val;
        end
        if (rd_en)
        begin
            link_q_reg   <= link_mem[rd_addr];
            rd_id_reg    <= id_mem[rd_addr];
            rd_val_reg   <= val_mem[rd_addr];
            rd_addr_reg  <= rd_addr;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.link_we)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_id  = rd_id_reg;
    assign rd_val = rd_val_reg;

    // reset chain: slot i links to i+1, last slot to null (== POOL_SLOTS)
    assign rd_link = rd_valid_reg ? link_q_reg
                                  : LINK_W'(rd_addr_reg) + LINK_W'(1);

endmodule

>>> rtl/watch_slot_pool.sv
// Watch slot pool: free/active linked lists over a slot store.
// Depends on wsp_pkg and wsp_store.
// A full pool, an unknown command or an empty active list is reported
// straight from idle; an allocate passes through S_ALLOC; a check or a
// delete walks the active list in S_SEARCH, and a delete below the list
// head adds an S_UNLINK step. A miss walks every active slot. The rate
// is set by the list walk: one link per cycle through the store's single
// read port. For a command that leaves idle, busy is high from accept
// until done rises. Reset is asynchronous and restores the empty pool.
module watch_slot_pool #(
    parameter int POOL_SLOTS = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [31:0] target_id,
    input  logic [31:0] watch_value,
    output logic        done,
    output logic [1:0]  status,
    output logic [4:0]  slot_number,
    output logic [31:0] assigned_id,
    output logic        changed,
    output logic [31:0] previous_value
);
    import wsp_pkg::*;

    localparam int SLOT_W = $clog2(POOL_SLOTS);
    localparam int LINK_W = $clog2(POOL_SLOTS + 1);
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_SLOTS);

    // control state
    wsp_state_t        state_reg, state_next;
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [LINK_W-1:0] active_head_reg, active_head_next;
    logic [ID_W-1:0]   id_cnt_reg, id_cnt_next;
    logic              done_reg, done_next;

    // command held for the duration of the walk
    logic [1:0]            cmd_reg, cmd_next;
    logic [ID_W-1:0]       tid_reg, tid_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [SLOT_W-1:0]     cur_reg, cur_next;     // slot being examined
    logic [LINK_W-1:0]     prev_reg, prev_next;   // slot before it, or null
    logic [LINK_W-1:0]     succ_reg, succ_next;   // link to splice on unlink

    // result registers
    logic [1:0]            status_reg, status_next;
    logic [SLOT_NUM_W-1:0] slot_reg, slot_next;
    logic [ID_W-1:0]       res_id_reg, res_id_next;
    logic                  changed_reg, changed_next;
    logic [RES_VAL_W-1:0]  prev_val_reg, prev_val_next;

    // store interface
    logic                  rd_en;
    logic [SLOT_W-1:0]     rd_addr;
    wsp_wr_t               wr;
    logic [SLOT_W-1:0]     wr_addr;
    logic [LINK_W-1:0]     wr_link;
    logic [ID_W-1:0]       wr_id;
    logic [VALUE_BITS-1:0] wr_val;
    logic [LINK_W-1:0]     rd_link;
    logic [ID_W-1:0]       rd_id;
    logic [VALUE_BITS-1:0] rd_val;

    logic [ID_W-1:0] id_inc;
    logic            hit;
    logic            tail;

    wsp_store #(
        .POOL_SLOTS (POOL_SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr      (wr),
        .wr_addr (wr_addr),
        .wr_link (wr_link),
        .wr_id   (wr_id),
        .wr_val  (wr_val),
        .rd_link (rd_link),
        .rd_id   (rd_id),
        .rd_val  (rd_val)
    );

    // ids start at 1 and stick at all ones
    assign id_inc = (id_cnt_reg == NO_ID) ? id_cnt_reg : id_cnt_reg + ID_W'(1);
    assign hit    = (rd_id == tid_reg);
    assign tail   = (rd_link == LINK_NULL);

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign slot_number    = slot_reg;
    assign assigned_id    = res_id_reg;
    assign changed        = changed_reg;
    assign previous_value = prev_val_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_ALLOC:
                        begin
                            if (free_head_reg != LINK_NULL)
                            begin
                                state_next = S_ALLOC;
                            end
                        end
                        CMD_DELETE, CMD_CHECK:
                        begin
                            if (active_head_reg != LINK_NULL)
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                state_next = S_IDLE;
            end
            S_SEARCH:
            begin
                priority if (hit)
                begin
                    if (cmd_reg == CMD_DELETE && prev_reg != LINK_NULL)
                    begin
                        state_next = S_UNLINK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (tail)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_UNLINK:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath, store control and results
    always_comb
    begin
        free_head_next   = free_head_reg;
        active_head_next = active_head_reg;
        id_cnt_next      = id_cnt_reg;
        done_next        = 1'b0;
        cmd_next         = cmd_reg;
        tid_next         = tid_reg;
        val_next         = val_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        succ_next        = succ_reg;
        status_next      = status_reg;
        slot_next        = slot_reg;
        res_id_next      = res_id_reg;
        changed_next     = changed_reg;
        prev_val_next    = prev_val_reg;
        rd_en            = 1'b0;
        rd_addr          = active_head_reg[SLOT_W-1:0];
        wr               = '0;
        wr_addr          = cur_reg;
        wr_link          = free_head_reg;
        wr_id            = NO_ID;
        wr_val           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next      = cmd;
                    tid_next      = target_id;
                    val_next      = VALUE_BITS'(watch_value);
                    prev_next     = LINK_NULL;
                    slot_next     = '0;
                    res_id_next   = '0;
                    changed_next  = 1'b0;
                    prev_val_next = '0;
                    unique case (cmd)
                        CMD_ALLOC:
                        begin
                            cur_next = free_head_reg[SLOT_W-1:0];
                            if (free_head_reg == LINK_NULL)
                            begin
                                status_next = ST_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                rd_en   = 1'b1;
                                rd_addr = free_head_reg[SLOT_W-1:0];
                            end
                        end
                        CMD_DELETE, CMD_CHECK:
                        begin
                            cur_next = active_head_reg[SLOT_W-1:0];
                            if (active_head_reg == LINK_NULL)
                            begin
                                status_next = ST_NOT_FOUND;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = ST_NOT_FOUND;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                // rd_link holds the popped slot's successor on the free list
                wr               = '{link_we: 1'b1, id_we: 1'b1, val_we: 1'b1};
                wr_link          = active_head_reg;
                wr_id            = id_inc;
                wr_val           = val_reg;
                free_head_next   = rd_link;
                active_head_next = LINK_W'(cur_reg);
                id_cnt_next      = id_inc;
                status_next      = ST_OK;
                slot_next        = SLOT_NUM_W'(cur_reg);
                res_id_next      = id_inc;
                done_next        = 1'b1;
            end
            S_SEARCH:
            begin
                priority if (hit)
                begin
                    status_next = ST_OK;
                    slot_next   = SLOT_NUM_W'(cur_reg);
                    res_id_next = rd_id;
                    if (cmd_reg == CMD_CHECK)
                    begin
                        wr.val_we     = 1'b1;
                        wr_val        = val_reg;
                        changed_next  = (val_reg != rd_val);
                        prev_val_next = RES_VAL_W'(rd_val);
                        done_next     = 1'b1;
                    end
                    else
                    begin
                        // push onto the free list, clear id and value
                        wr             = '{link_we: 1'b1, id_we: 1'b1, val_we: 1'b1};
                        wr_link        = free_head_reg;
                        wr_id          = NO_ID;
                        wr_val         = '0;
                        free_head_next = LINK_W'(cur_reg);
                        if (prev_reg == LINK_NULL)
                        begin
                            active_head_next = rd_link;
                            done_next        = 1'b1;
                        end
                        else
                        begin
                            succ_next = rd_link;
                        end
                    end
                end
                else if (tail)
                begin
                    status_next = ST_NOT_FOUND;
                    done_next   = 1'b1;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = rd_link[SLOT_W-1:0];
                    prev_next = LINK_W'(cur_reg);
                    cur_next  = rd_link[SLOT_W-1:0];
                end
            end
            S_UNLINK:
            begin
                // second link write: predecessor skips the freed slot
                wr.link_we = 1'b1;
                wr_addr    = prev_reg[SLOT_W-1:0];
                wr_link    = succ_reg;
                done_next  = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            free_head_reg   <= '0;
            active_head_reg <= LINK_NULL;
            id_cnt_reg      <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            free_head_reg   <= free_head_next;
            active_head_reg <= active_head_next;
            id_cnt_reg      <= id_cnt_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        tid_reg      <= tid_next;
        val_reg      <= val_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        succ_reg     <= succ_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        res_id_reg   <= res_id_next;
        changed_reg  <= changed_next;
        prev_val_reg <= prev_val_next;
    end

endmodule

>>> rtl/wsp_checker.sv
// Port-level checks for watch_slot_pool, attached by bind.
// Depends on wsp_pkg and watch_slot_pool_defines.svh.
`include "watch_slot_pool_defines.svh"

module wsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [4:0]  slot_number,
    input logic [31:0] assigned_id,
    input logic        changed,
    input logic [31:0] previous_value
);
    import wsp_pkg::*;

    // a results transfer only shows while the block is idle
    `WSP_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)

    // an accepted command either reports at once or keeps the block busy
    `WSP_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || done)

    // leaving busy always comes with a result
    `WSP_ASSERT_NOW(a_busy_ends_done, clk, rst_n, $fell(busy), done)

    // failed commands carry zero fields
    `WSP_ASSERT_NOW(a_fail_zero, clk, rst_n, done && status != ST_OK,
        slot_number == 5'd0 && assigned_id == 32'd0 && !changed && previous_value == 32'd0)

    // only a successful command can report a change
    `WSP_ASSERT_NOW(a_changed_ok, clk, rst_n, done && changed, status == ST_OK)

endmodule

bind watch_slot_pool wsp_checker u_wsp_checker (.*);
